// ===== hdl/mu2x_pkg.sv =====
// Package for the mu-law 2x interpolator: sizes, Q15 coefficients, G.711 expansion.
package mu2x_pkg;

    localparam int TAPS_DEFAULT = 16;
    localparam int COEF_W       = 17;
    localparam int SAMPLE_W     = 16;
    localparam int PROD_W       = COEF_W + SAMPLE_W;
    localparam int COEF_IDX_W   = 7;

    localparam logic signed [COEF_W-1:0] CENTRE_COEF = 17'sd32685;

    // even-phase Q15 coefficients; entries past the sixteenth are zero
    function automatic logic signed [COEF_W-1:0] even_coef(input logic [COEF_IDX_W-1:0] idx);
        logic signed [COEF_W-1:0] c;
        unique case (idx)
            7'd0:    c = -17'sd115;
            7'd1:    c =  17'sd164;
            7'd2:    c = -17'sd376;
            7'd3:    c =  17'sd818;
            7'd4:    c = -17'sd1609;
            7'd5:    c =  17'sd3034;
            7'd6:    c = -17'sd6132;
            7'd7:    c =  17'sd20391;
            7'd8:    c =  17'sd20808;
            7'd9:    c = -17'sd6525;
            7'd10:   c =  17'sd3381;
            7'd11:   c = -17'sd1894;
            7'd12:   c =  17'sd1030;
            7'd13:   c = -17'sd511;
            7'd14:   c =  17'sd227;
            7'd15:   c = -17'sd115;
            default: c =  17'sd0;
        endcase
        return c;
    endfunction

    // G.711 mu-law to 16-bit linear
    function automatic logic signed [SAMPLE_W-1:0] mulaw_expand(input logic [7:0] code);
        logic [7:0]  u;
        logic [15:0] mag;
        u   = ~code;
        mag = ({9'd0, u[3:0], 3'd0} + 16'h0084) << u[6:4];
        return u[7] ? signed'(16'h0084 - mag) : signed'(mag - 16'h0084);
    endfunction

endpackage

// ===== hdl/mulaw_upsample_2x_fir.sv =====
// mulaw_upsample_2x_fir: 2x polyphase interpolator for G.711 mu-law audio.
//
// Input channel (in_valid/in_ready): one mu-law byte per beat plus a block_end
// flag. Output channel (out_valid/out_ready): two beats per input, the even-phase
// FIR sample first (last_of_pair = 0), then the centre-tap sample
// (last_of_pair = 1); block_end_out copies block_end on both.
// One 17x16 multiplier is shared: it runs TAPS even-phase products and then
// the centre product, one per cycle, while the history rotates through its
// read tap. out_valid rises from S_WAIT, once the multiply-accumulate loop is
// done; with the receiver always ready, that loop sets the item rate.
// in_ready is high only while idle.
// If the receiver stalls, the pending output beat holds in the output register
// and no new input is taken until both beats are gone.
// Reset clears the sample history to zero and empties the output register.
module mulaw_upsample_2x_fir
    import mu2x_pkg::*;
#(
    parameter int TAPS = TAPS_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] mu_byte,
    input  logic       block_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] sample_out,
    output logic       last_of_pair,
    output logic       block_end_out
);

    localparam int CNT_W  = $clog2(TAPS + 1);
    localparam int CENTRE = TAPS / 2 - 1;

    typedef enum logic [2:0] {S_IDLE, S_MAC, S_WAIT, S_OUT0, S_OUT1} state_t;

    state_t                      state_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic signed [SAMPLE_W-1:0]  hist_reg [TAPS];
    logic signed [PROD_W-1:0]    prod_reg;
    logic                        prod_vld_reg;
    logic                        prod_ctr_reg;
    logic [SAMPLE_W-1:0]         acc_reg;
    logic [SAMPLE_W-1:0]         ctr_q_reg;
    logic                        be_reg;
    logic                        out_valid_reg;
    logic [7:0]                  sample_reg;
    logic                        last_reg;

    logic                        last_issue;
    logic signed [COEF_W-1:0]    mul_a;
    logic signed [SAMPLE_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]    prod_next;
    logic [SAMPLE_W-1:0]         quot;
    logic [SAMPLE_W-1:0]         acc_next;

    function automatic logic [7:0] finish(input logic [SAMPLE_W-1:0] v);
        logic [SAMPLE_W-1:0] y;
        y = v + 16'd128;
        return y[15:8] + 8'd127;
    endfunction

    assign last_issue = (cnt_reg == CNT_W'(TAPS));

    // shared multiplier: even taps read the rotating head, centre reads a fixed tap
    assign mul_a     = last_issue ? CENTRE_COEF : even_coef(COEF_IDX_W'(cnt_reg));
    assign mul_b     = last_issue ? hist_reg[CENTRE] : hist_reg[0];
    assign prod_next = mul_a * mul_b;

    // divide by 2^15 toward zero, keep 16 bits
    assign quot     = prod_reg[30:15]
                    + {15'd0, prod_reg[PROD_W-1] & (|prod_reg[14:0])};
    assign acc_next = acc_reg + quot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            for (int k = 0; k < TAPS; k++)
                hist_reg[k] <= '0;
            prod_reg      <= '0;
            prod_vld_reg  <= 1'b0;
            prod_ctr_reg  <= 1'b0;
            acc_reg       <= '0;
            ctr_q_reg     <= '0;
            be_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            sample_reg    <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= (state_reg == S_MAC);
            if (prod_vld_reg && !prod_ctr_reg)
                acc_reg <= acc_next;
            if (prod_vld_reg && prod_ctr_reg)
                ctr_q_reg <= quot;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        for (int k = TAPS - 1; k > 0; k--)
                            hist_reg[k] <= hist_reg[k-1];
                        hist_reg[0] <= mulaw_expand(mu_byte);
                        be_reg      <= block_end;
                        acc_reg     <= '0;
                        cnt_reg     <= '0;
                        state_reg   <= S_MAC;
                    end
                end
                S_MAC:
                begin
                    prod_reg     <= prod_next;
                    prod_ctr_reg <= last_issue;
                    if (last_issue)
                        state_reg <= S_WAIT;
                    else
                    begin
                        // rotate so the next tap sits at the head
                        for (int k = 0; k < TAPS - 1; k++)
                            hist_reg[k] <= hist_reg[k+1];
                        hist_reg[TAPS-1] <= hist_reg[0];
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_WAIT:
                begin
                    out_valid_reg <= 1'b1;
                    sample_reg    <= finish(acc_reg);
                    last_reg      <= 1'b0;
                    state_reg     <= S_OUT0;
                end
                S_OUT0:
                begin
                    if (out_ready)
                    begin
                        sample_reg <= finish(ctr_q_reg);
                        last_reg   <= 1'b1;
                        state_reg  <= S_OUT1;
                    end
                end
                S_OUT1:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign sample_out    = sample_reg;
    assign last_of_pair  = last_reg;
    assign block_end_out = be_reg;

`ifndef SYNTH
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && in_ready))
        else $error("input taken while output pending");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_pair |=> out_valid && last_of_pair)
        else $error("second beat of pair missing");

    a_pair_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_of_pair |=> !out_valid && in_ready)
        else $error("extra beat after pair");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready && !out_valid)
        else $error("sequencer did not start");
`endif

endmodule

// ===== sim/mulaw_upsample_2x_fir_test.sv =====
// Self-checking testbench for the mu-law 2x interpolator: directed table, then random beats.
module mulaw_upsample_2x_fir_test;

    import mu2x_pkg::*;

    localparam int HIST         = TAPS_DEFAULT;
    localparam int CENTRE_IDX   = HIST / 2 - 1;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RAND_PER_PHASE = 350;
    localparam int DIR_ROWS     = 25;

    typedef struct packed {
        logic [7:0] sample;
        logic       last;
        logic       be;
    } out_beat_t;

    typedef struct packed {
        logic [7:0] code;
        logic       be;
        logic       known;
        logic [7:0] first;
        logic [7:0] second;
    } stim_row_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] mu_byte;
    logic       block_end;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] sample_out;
    logic       last_of_pair;
    logic       block_end_out;

    // even-phase Q15 taps and the centre tap
    int fir_even [16] = '{
        -115, 164, -376, 818, -1609, 3034, -6132, 20391,
        20808, -6525, 3381, -1894, 1030, -511, 227, -115
    };
    int centre_gain = 32685;

    logic signed [15:0] pcm_hist [HIST];
    out_beat_t          pending_samples [$];

    int send_idle;
    int recv_idle;
    int errors;
    int bytes_sent;
    int beats_checked;
    int block_ends_seen;
    int cycles;

    // rows with known set carry hand-worked results: history is all zero there
    stim_row_t dir_table [DIR_ROWS] = '{
        '{8'hFF, 1'b0, 1'b1, 8'd127, 8'd127},
        '{8'h7F, 1'b1, 1'b1, 8'd127, 8'd127},
        '{8'hFF, 1'b0, 1'b1, 8'd127, 8'd127},
        '{8'h00, 1'b0, 1'b0, 8'd0, 8'd0},
        '{8'h80, 1'b1, 1'b0, 8'd0, 8'd0},
        '{8'h7E, 1'b0, 1'b0, 8'd0, 8'd0},
        '{8'hFE, 1'b0, 1'b0, 8'd0, 8'd0},
        '{8'h01, 1'b1, 1'b0, 8'd0, 8'd0},
        '{8'h81, 1'b0, 1'b0, 8'd0, 8'd0},
        // full-scale samples with signs matching the taps: the sum wraps
        '{8'h00, 1'b0, 1'b0, 8'd0, 8'd0},
        '{8'h80, 1'b0, 1'b0, 8'd0, 8'd0},
        '{8'h00, 1'b0, 1'b0, 8'd0, 8'd0},
        '{8'h80, 1'b0, 1'b0, 8'd0, 8'd0},
        '{8'h00, 1'b0, 1'b0, 8'd0, 8'd0},
        '{8'h80, 1'b0, 1'b0, 8'd0, 8'd0},
        '{8'h00, 1'b0, 1'b0, 8'd0, 8'd0},
        '{8'h80, 1'b0, 1'b0, 8'd0, 8'd0},
        '{8'h80, 1'b0, 1'b0, 8'd0, 8'd0},
        '{8'h00, 1'b0, 1'b0, 8'd0, 8'd0},
        '{8'h80, 1'b0, 1'b0, 8'd0, 8'd0},
        '{8'h00, 1'b0, 1'b0, 8'd0, 8'd0},
        '{8'h80, 1'b0, 1'b0, 8'd0, 8'd0},
        '{8'h00, 1'b0, 1'b0, 8'd0, 8'd0},
        '{8'h80, 1'b0, 1'b0, 8'd0, 8'd0},
        '{8'h00, 1'b1, 1'b0, 8'd0, 8'd0}
    };

    mulaw_upsample_2x_fir DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mu_byte       (mu_byte),
        .block_end     (block_end),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .sample_out    (sample_out),
        .last_of_pair  (last_of_pair),
        .block_end_out (block_end_out)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [15:0] g711_decode(input logic [7:0] code);
        logic [7:0] inv;
        int         mag;
        inv = ~code;
        mag = (int'(inv[3:0]) * 8 + 132) << inv[6:4];
        return inv[7] ? 16'(132 - mag) : 16'(mag - 132);
    endfunction

    // product scaled back by 2^15, truncated toward zero, kept to 16 bits
    function automatic logic signed [15:0] q15_mul(input int coef, input logic signed [15:0] s);
        int p;
        p = coef * int'(s);
        return 16'(p / 32768);
    endfunction

    function automatic logic [7:0] to_offset8(input logic signed [15:0] acc);
        logic signed [15:0] rounded;
        logic signed [15:0] shifted;
        rounded = acc + 16'sd128;
        shifted = rounded >>> 8;
        return 8'(shifted + 16'sd127);
    endfunction

    // shift a new sample into the history and form both output samples
    task automatic interp_pair(input logic [7:0] code, output logic [7:0] first,
                               output logic [7:0] second);
        logic signed [15:0] acc;
        int                 coef;
        for (int i = HIST - 1; i > 0; i--)
            pcm_hist[i] = pcm_hist[i - 1];
        pcm_hist[0] = g711_decode(code);
        acc = '0;
        for (int i = 0; i < HIST; i++)
        begin
            coef = (i < 16) ? fir_even[i] : 0;
            acc  = acc + q15_mul(coef, pcm_hist[i]);
        end
        first  = to_offset8(acc);
        second = to_offset8(q15_mul(centre_gain, pcm_hist[CENTRE_IDX]));
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0d want %0d", cycles, what, got, want);
        errors++;
    endtask

    task automatic send_byte(input logic [7:0] code, input logic be, input logic known,
                             input logic [7:0] known_first, input logic [7:0] known_second);
        logic [7:0] first;
        logic [7:0] second;
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle);
        end
        in_valid  <= 1'b1;
        mu_byte   <= code;
        block_end <= be;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        interp_pair(code, first, second);
        if (known)
        begin
            first  = known_first;
            second = known_second;
        end
        pending_samples.push_back('{first, 1'b0, be});
        pending_samples.push_back('{second, 1'b1, be});
        bytes_sent++;
    endtask

    function automatic logic [7:0] pick_code();
        if ($urandom_range(3) == 0)
        begin
            case ($urandom_range(7))
                0: return 8'h00;
                1: return 8'h80;
                2: return 8'h7F;
                3: return 8'hFF;
                4: return 8'h01;
                5: return 8'h81;
                6: return 8'h7E;
                default: return 8'hFE;
            endcase
        end
        return 8'($urandom_range(255));
    endfunction

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin : out_side
        out_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_samples.size() == 0)
                report_mismatch("unexpected beat, sample_out", sample_out, -1);
            else
            begin
                want = pending_samples.pop_front();
                if (sample_out !== want.sample)
                    report_mismatch("sample_out", sample_out, want.sample);
                if (last_of_pair !== want.last)
                    report_mismatch("last_of_pair", last_of_pair, want.last);
                if (block_end_out !== want.be)
                    report_mismatch("block_end_out", block_end_out, want.be);
                beats_checked++;
                if (want.be)
                    block_ends_seen++;
            end
        end
        out_ready <= rst_n && ($urandom_range(99) >= recv_idle);
    end

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        mu_byte         = 8'd0;
        block_end       = 1'b0;
        out_ready       = 1'b0;
        errors          = 0;
        bytes_sent      = 0;
        beats_checked   = 0;
        block_ends_seen = 0;
        cycles          = 0;
        send_idle       = 7;
        recv_idle       = 70;
        for (int i = 0; i < HIST; i++)
            pcm_hist[i] = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_table[i])
            send_byte(dir_table[i].code, dir_table[i].be, dir_table[i].known,
                      dir_table[i].first, dir_table[i].second);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle = (phase == 0) ? 7 : (phase == 1) ? 70 : 0;
            recv_idle = (phase == 0) ? 70 : (phase == 1) ? 7 : 0;
            for (int n = 0; n < RAND_PER_PHASE; n++)
                send_byte(pick_code(), $urandom_range(7) == 0, 1'b0, 8'd0, 8'd0);
        end
        in_valid <= 1'b0;

        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d mu-law bytes sent, %0d output beats checked (%0d flagged block end)",
                 bytes_sent, beats_checked, block_ends_seen);
        $display("idle mixes: sender-light/receiver-heavy, reversed, none; %0d mismatches",
                 errors);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
